@@ rtl/trd_pkg.sv @@
// Package: shared types and constants of the tag record reply deframer.
package trd_pkg;

  localparam int RECORD_CAP_DEF           = 16;
  localparam int LIVE_FRAME_BYTES_DEF     = 20;
  localparam int PLAYBACK_FRAME_BYTES_DEF = 7;

  localparam int LIVE_HEADER_BYTES     = 2;
  localparam int PLAYBACK_HEADER_BYTES = 17;

  localparam int CMD_DEPTH = 2;

  localparam logic [4:0] RECORD_LIMIT_RESET = 5'd16;
  localparam logic [2:0] ADDR_RECORD_LIMIT  = 3'd0;

  localparam logic [15:0] MILLIS_MAX  = 16'd999;
  localparam logic [15:0] MILLIS_WRAP = 16'd1000;

  typedef enum logic [1:0] {
    KIND_LIVE   = 2'd0,
    KIND_PB     = 2'd1,
    KIND_HEADER = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_STORE_CODE = 3'd0,
    OP_STORE_A0   = 3'd1,
    OP_STORE_A1   = 3'd2,
    OP_EMIT_LIVE  = 3'd3,
    OP_EMIT_PB    = 3'd4,
    OP_EMIT_HDR   = 3'd5,
    OP_EMIT_ERR   = 3'd6
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] slot;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [47:0] tag_code;
    logic [31:0] rec_seconds;
    logic [15:0] millis;
    logic [7:0]  peak_rssi;
    logic [7:0]  wakeups;
    logic [7:0]  battery_level;
    logic [15:0] loop_word;
    logic [31:0] boot_count;
    logic [31:0] bt_time;
    logic [7:0]  firmware_version;
    logic        last;
  } res_t;

endpackage

@@ rtl/tag_record_reply_deframer.sv @@
// Top level of the tag record reply deframer: config register, front, queue, back.
//
// Takes one reply byte per cycle, sustained, as long as results are popped;
// a byte that produces a record has its item written into the two-entry
// command queue at the edge that accepts it, and moved from there into the
// result register that drives the result ports once that register is free. full
// rises only when the command queue is full, which happens when the result
// register is held by a consumer that does not pop. Bytes that carry nothing
// (ignored bytes, live header and pad bytes, the first two playback header
// bytes) take no queue slot. record_limit at address 0 is sampled at each start.
module tag_record_reply_deframer #(
  parameter int RECORD_CAP           = trd_pkg::RECORD_CAP_DEF,
  parameter int LIVE_FRAME_BYTES     = trd_pkg::LIVE_FRAME_BYTES_DEF,
  parameter int PLAYBACK_FRAME_BYTES = trd_pkg::PLAYBACK_FRAME_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        rx_byte_i,
  input  logic              start_of_reply_i,
  input  logic              playback_type_i,
  input  logic [7:0]        record_count_i,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        item_kind_o,
  output logic [47:0]       tag_code_o,
  output logic [31:0]       rec_seconds_o,
  output logic [15:0]       millis_o,
  output logic signed [7:0] peak_rssi_o,
  output logic [7:0]        wakeups_o,
  output logic [7:0]        battery_level_o,
  output logic [15:0]       loop_word_o,
  output logic [31:0]       boot_count_o,
  output logic [31:0]       bt_time_o,
  output logic [7:0]        firmware_version_o,
  output logic              last_item_o
);
  import trd_pkg::*;

  logic [4:0] limit_q;
  logic       accept;
  logic       f_valid, q_valid, q_pop, q_full, r_valid;
  cmd_t       f_cmd, q_cmd;
  res_t       res;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_RECORD_LIMIT) ? {27'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= RECORD_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_RECORD_LIMIT) begin
      limit_q <= pwdata[4:0];
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  trd_front #(
    .RECORD_CAP          (RECORD_CAP),
    .LIVE_FRAME_BYTES    (LIVE_FRAME_BYTES),
    .PLAYBACK_FRAME_BYTES(PLAYBACK_FRAME_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .rx_byte_i       (rx_byte_i),
    .start_of_reply_i(start_of_reply_i),
    .playback_type_i (playback_type_i),
    .record_count_i  (record_count_i),
    .record_limit_i  (limit_q),
    .cmd_valid_o     (f_valid),
    .cmd_o           (f_cmd)
  );

  trd_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (f_valid),
    .wr_data_i(f_cmd),
    .full_o   (q_full),
    .rd_i     (q_pop),
    .valid_o  (q_valid),
    .rd_data_o(q_cmd)
  );

  trd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_cmd),
    .cmd_pop_o  (q_pop),
    .res_valid_o(r_valid),
    .res_o      (res),
    .res_pop_i  (pop && r_valid)
  );

  assign empty              = !r_valid;
  assign item_kind_o        = res.kind;
  assign tag_code_o         = res.tag_code;
  assign rec_seconds_o      = res.rec_seconds;
  assign millis_o           = res.millis;
  assign peak_rssi_o        = res.peak_rssi;
  assign wakeups_o          = res.wakeups;
  assign battery_level_o    = res.battery_level;
  assign loop_word_o        = res.loop_word;
  assign boot_count_o       = res.boot_count;
  assign bt_time_o          = res.bt_time;
  assign firmware_version_o = res.firmware_version;
  assign last_item_o        = res.last;

endmodule

@@ rtl/trd_front.sv @@
// Front end: tracks transaction state per byte and issues store/emit commands.
module trd_front #(
  parameter int RECORD_CAP           = trd_pkg::RECORD_CAP_DEF,
  parameter int LIVE_FRAME_BYTES     = trd_pkg::LIVE_FRAME_BYTES_DEF,
  parameter int PLAYBACK_FRAME_BYTES = trd_pkg::PLAYBACK_FRAME_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          start_of_reply_i,
  input  logic          playback_type_i,
  input  logic [7:0]    record_count_i,
  input  logic [4:0]    record_limit_i,
  output logic          cmd_valid_o,
  output trd_pkg::cmd_t cmd_o
);
  import trd_pkg::*;

  logic       mode_q, mode_d;
  logic [7:0] left_q, left_d;
  logic [4:0] pos_q, pos_d;
  logic       hdr_q, hdr_d;
  logic       ign_q, ign_d;

  logic       e_mode, e_hdr, e_ign, err;
  logic [7:0] e_left, left_n;
  logic [4:0] e_pos;
  logic [5:0] pos1, hlen, flen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      left_q <= '0;
      pos_q  <= '0;
      hdr_q  <= 1'b0;
      ign_q  <= 1'b1;
    end else begin
      mode_q <= mode_d;
      left_q <= left_d;
      pos_q  <= pos_d;
      hdr_q  <= hdr_d;
      ign_q  <= ign_d;
    end
  end

  always_comb begin
    mode_d = mode_q;
    left_d = left_q;
    pos_d  = pos_q;
    hdr_d  = hdr_q;
    ign_d  = ign_q;
    e_mode = mode_q;
    e_left = left_q;
    e_pos  = pos_q;
    e_hdr  = hdr_q;
    e_ign  = ign_q;
    err    = 1'b0;
    left_n = '0;
    pos1   = {1'b0, pos_q} + 6'd1;
    hlen   = 6'(LIVE_HEADER_BYTES);
    flen   = 6'(LIVE_FRAME_BYTES);
    cmd_valid_o  = 1'b0;
    cmd_o.op     = OP_STORE_CODE;
    cmd_o.slot   = '0;
    cmd_o.data   = rx_byte_i;
    cmd_o.last   = 1'b0;
    if (accept_i) begin
      if (start_of_reply_i) begin
        e_mode = playback_type_i;
        e_pos  = '0;
        e_hdr  = 1'b1;
        if (record_count_i > 8'(RECORD_CAP)) begin
          err = 1'b1;
        end else begin
          e_left = (record_count_i < {3'b0, record_limit_i}) ? record_count_i
                                                             : {3'b0, record_limit_i};
          e_ign  = !e_mode && (e_left == 8'd0);
        end
      end
      mode_d = e_mode;
      pos_d  = e_pos;
      hdr_d  = e_hdr;
      left_d = e_left;
      ign_d  = e_ign;
      pos1   = {1'b0, e_pos} + 6'd1;
      hlen   = e_mode ? 6'(PLAYBACK_HEADER_BYTES) : 6'(LIVE_HEADER_BYTES);
      flen   = e_mode ? 6'(PLAYBACK_FRAME_BYTES) : 6'(LIVE_FRAME_BYTES);
      if (err) begin
        ign_d       = 1'b1;
        left_d      = '0;
        cmd_valid_o = 1'b1;
        cmd_o.op    = OP_EMIT_ERR;
        cmd_o.last  = 1'b1;
      end else if (!e_ign) begin
        if (e_hdr) begin
          if (e_mode) begin
            if (e_pos >= 5'd2 && e_pos <= 5'd7) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = OP_STORE_CODE;
              cmd_o.slot  = 3'(e_pos - 5'd2);
            end else if (e_pos >= 5'd8 && e_pos <= 5'd15) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = OP_STORE_A0;
              cmd_o.slot  = e_pos[2:0];
            end
          end
          if (pos1 >= hlen) begin
            hdr_d = 1'b0;
            pos_d = '0;
            if (e_mode) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = OP_EMIT_HDR;
              cmd_o.last  = (e_left == 8'd0);
              if (e_left == 8'd0) begin
                ign_d = 1'b1;
              end
            end
          end else begin
            pos_d = pos1[4:0];
          end
        end else begin
          left_n = (e_left != 8'd0) ? e_left - 8'd1 : 8'd0;
          if (e_mode) begin
            if (e_pos < 5'd6) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = OP_STORE_A0;
              cmd_o.slot  = e_pos[2:0];
            end else if (e_pos == 5'd6) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = OP_EMIT_PB;
            end
          end else begin
            if (e_pos < 5'd8) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = OP_STORE_A0;
              cmd_o.slot  = e_pos[2:0];
            end else if (e_pos == 5'd8) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = OP_STORE_A1;
              cmd_o.slot  = 3'd0;
            end else if (e_pos >= 5'd10 && e_pos <= 5'd16) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = OP_STORE_A1;
              cmd_o.slot  = 3'(e_pos - 5'd9);
            end else if (e_pos == 5'd17) begin
              cmd_valid_o = 1'b1;
              cmd_o.op    = OP_EMIT_LIVE;
            end
          end
          if (cmd_o.op == OP_EMIT_LIVE || cmd_o.op == OP_EMIT_PB) begin
            left_d     = left_n;
            cmd_o.last = (left_n == 8'd0);
            if (left_n == 8'd0) begin
              ign_d = 1'b1;
            end
          end
          pos_d = (pos1 >= flen) ? 5'd0 : pos1[4:0];
        end
      end
    end
  end

endmodule

@@ rtl/trd_cmd_fifo.sv @@
// Command queue between front end and back end.
module trd_cmd_fifo #(
  parameter int DEPTH = trd_pkg::CMD_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  trd_pkg::cmd_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          valid_o,
  output trd_pkg::cmd_t rd_data_o
);
  import trd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          do_wr, do_rd;

  assign full_o    = (cnt_q == (AW + 1)'(DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rp_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
      end
      if (do_rd) begin
        rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + (AW + 1)'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - (AW + 1)'(1);
      end
    end
  end

endmodule

@@ rtl/trd_back.sv @@
// Back end: assembles frame bytes and builds result items into the output register.
module trd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  trd_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          res_valid_o,
  output trd_pkg::res_t res_o,
  input  logic          res_pop_i
);
  import trd_pkg::*;

  logic [47:0] code_q;
  logic [63:0] a0_q, a1_q;
  logic        valid_q;
  res_t        res_q, res_d;
  logic        is_emit, slot_ok;
  logic [31:0] dt;
  logic [15:0] ms;

  assign is_emit     = (cmd_i.op == OP_EMIT_LIVE) || (cmd_i.op == OP_EMIT_PB) ||
                       (cmd_i.op == OP_EMIT_HDR) || (cmd_i.op == OP_EMIT_ERR);
  assign slot_ok     = !valid_q || res_pop_i;
  assign cmd_pop_o   = cmd_valid_i && (!is_emit || slot_ok);
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    dt    = a0_q[31:0];
    ms    = a0_q[47:32];
    if (ms > MILLIS_MAX) begin
      ms = ms - MILLIS_WRAP;
      dt = dt + 32'd1;
    end
    res_d      = '0;
    res_d.last = cmd_i.last;
    case (cmd_i.op)
      OP_EMIT_LIVE: begin
        res_d.kind          = KIND_LIVE;
        res_d.tag_code      = {cmd_i.data, a1_q[63:24]};
        res_d.rec_seconds   = dt;
        res_d.millis        = ms;
        res_d.peak_rssi     = a0_q[55:48];
        res_d.wakeups       = a0_q[63:56];
        res_d.battery_level = a1_q[7:0];
        res_d.loop_word     = a1_q[23:8];
      end
      OP_EMIT_PB: begin
        res_d.kind        = KIND_PB;
        res_d.tag_code    = code_q;
        res_d.rec_seconds = a0_q[39:8];
        res_d.millis      = {cmd_i.data, a0_q[47:40]};
        res_d.loop_word   = {6'd0, a0_q[3:0], 6'd0};
      end
      OP_EMIT_HDR: begin
        res_d.kind             = KIND_HEADER;
        res_d.tag_code         = code_q;
        res_d.boot_count       = a0_q[31:0];
        res_d.bt_time          = a0_q[63:32];
        res_d.firmware_version = cmd_i.data;
      end
      default: begin
        res_d.kind = KIND_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      case (cmd_i.op)
        OP_STORE_CODE: begin
          for (int i = 0; i < 6; i++) begin
            if (cmd_i.slot == 3'(i)) code_q[i*8 +: 8] <= cmd_i.data;
          end
        end
        OP_STORE_A0: begin
          for (int i = 0; i < 8; i++) begin
            if (cmd_i.slot == 3'(i)) a0_q[i*8 +: 8] <= cmd_i.data;
          end
        end
        OP_STORE_A1: begin
          for (int i = 0; i < 8; i++) begin
            if (cmd_i.slot == 3'(i)) a1_q[i*8 +: 8] <= cmd_i.data;
          end
        end
        default: begin
          res_q <= res_d;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_pop_o && is_emit) begin
      valid_q <= 1'b1;
    end else if (res_pop_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule
